[hw/rtl/tmcw_pkg.sv]
// Package for the text mode console writer: screen geometry, widths,
// command and state codes, and the queue and result types.
// No dependencies.
`default_nettype none

package tmcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);

  localparam int CMD_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int CELL_ADR_W = 11;
  localparam int CELL_W     = 16;
  localparam int COL_OUT_W  = 7;
  localparam int ROW_OUT_W  = 5;
  localparam int ATTR_W     = 8;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    OP_PUT,
    OP_LF,
    OP_CR,
    OP_CLEAR,
    OP_READ,
    OP_READ_OOR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
    logic [ADDR_W-1:0] addr;
  } qent_t;

  typedef struct packed {
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic [CELL_W-1:0]    cdata;
  } res_t;

  localparam int RES_W = $bits(res_t);

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_READ,
    BK_SCROLL,
    BK_BLANK,
    BK_CLEAR
  } bk_state_t;

endpackage

`default_nettype wire

[hw/rtl/text_mode_console_writer_core.sv]
// Text mode console writer: 80x25 cell screen with cursor, put/clear/read.
// Put, CR, LF without scroll and out-of-range read load the result register from idle;
// read goes through the memory read register first. Scroll: row copy one cell a cycle,
// bottom row blank. One put per cycle, set by the memory port, while results are taken
// and no scroll or clear runs. Reset: synchronous; clearing pass with in_tready low.
`default_nettype none

module text_mode_console_writer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // char_code[7:0], cell_address[18:8], zero pad
  input  wire logic [1:0]  in_tuser,   // command[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // cell_data[15:0], col_after[22:16], row_after[27:23]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data    // attribute[7:0]
);
  import tmcw_pkg::*;

  logic [ATTR_W-1:0] attr_r;
  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_valid;
  logic              init_busy;
  qent_t             q_wdata;
  qent_t             q_head;
  res_t              res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (cfg_valid) begin
      attr_r <= cfg_data;
    end
  end

  tmcw_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .in_char   (in_tdata[7:0]),
    .in_addr   (in_tdata[18:8]),
    .q_full    (q_full),
    .init_busy (init_busy),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  tmcw_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wdata   (q_wdata),
    .pop     (q_pop),
    .full    (q_full),
    .q_valid (q_valid),
    .head    (q_head)
  );

  tmcw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .attr      (attr_r),
    .q_valid   (q_valid),
    .head      (q_head),
    .pop       (q_pop),
    .init_busy (init_busy),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {(32 - RES_W)'(0), res};

endmodule

`default_nettype wire

[hw/rtl/tmcw_front.sv]
// Front end: input handshake and command classification into queue entries.
// Depends on tmcw_pkg.
`default_nettype none

module tmcw_front (
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [tmcw_pkg::CMD_W-1:0]    in_cmd,
  input  wire logic [tmcw_pkg::CHAR_W-1:0]   in_char,
  input  wire logic [tmcw_pkg::CELL_ADR_W-1:0] in_addr,
  input  wire logic                          q_full,
  input  wire logic                          init_busy,
  output logic                               q_push,
  output tmcw_pkg::qent_t                    q_wdata
);
  import tmcw_pkg::*;

  assign in_tready = !q_full && !init_busy;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    q_wdata.ch   = in_char;
    q_wdata.addr = ADDR_W'(in_addr);
    case (in_cmd)
      CMD_PUT: begin
        if (in_char == CH_LF) begin
          q_wdata.op = OP_LF;
        end else if (in_char == CH_CR) begin
          q_wdata.op = OP_CR;
        end else begin
          q_wdata.op = OP_PUT;
        end
      end
      CMD_CLEAR: q_wdata.op = OP_CLEAR;
      CMD_READ: begin
        if (32'(in_addr) < CELL_COUNT) begin
          q_wdata.op = OP_READ;
        end else begin
          q_wdata.op = OP_READ_OOR;
        end
      end
      default: q_wdata.op = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/tmcw_queue.sv]
// Short command queue between the front end and the back end.
// Depends on tmcw_pkg.
`default_nettype none

module tmcw_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire tmcw_pkg::qent_t  wdata,
  input  wire logic             pop,
  output logic                  full,
  output logic                  q_valid,
  output tmcw_pkg::qent_t       head
);
  import tmcw_pkg::*;

  qent_t             ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign head    = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == QDEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == QDEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tmcw_back.sv]
// Back end: screen memory, cursor, scroll and clear sweeps, result register.
// Depends on tmcw_pkg.
`default_nettype none

module tmcw_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [tmcw_pkg::ATTR_W-1:0] attr,
  input  wire logic                        q_valid,
  input  wire tmcw_pkg::qent_t             head,
  output logic                             pop,
  output logic                             init_busy,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output tmcw_pkg::res_t                   res
);
  import tmcw_pkg::*;

  logic [CELL_W-1:0] cells_r [CELL_COUNT];
  logic [CELL_W-1:0] rdata_r;

  bk_state_t         state_r, state_nxt;
  logic [ADDR_W-1:0] scan_r, scan_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              res_valid_r, res_valid_nxt;
  res_t              res_r;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr;
  logic              ld;
  logic [CELL_W-1:0] ld_cell;
  logic              out_free;
  logic [ADDR_W-1:0] cur_addr;

  localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] SCROLL_END  = ADDR_W'(CELL_COUNT - COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);

  assign out_free  = !res_valid_r || res_ready;
  assign cur_addr  = ADDR_W'(ADDR_W'(row_r) * ADDR_W'(COLUMNS)) + ADDR_W'(col_r);
  assign init_busy = (state_r == BK_INIT);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    we            = 1'b0;
    waddr         = scan_r;
    wdata         = BLANK_CELL;
    raddr         = (scan_r < SCROLL_END) ? scan_r + ADDR_W'(COLUMNS) : scan_r;
    pop           = 1'b0;
    ld            = 1'b0;
    ld_cell       = '0;
    case (state_r)
      BK_INIT, BK_CLEAR: begin
        we = 1'b1;
        if (scan_r == LAST_CELL) begin
          scan_nxt  = '0;
          state_nxt = BK_IDLE;
          ld        = (state_r == BK_CLEAR);
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      BK_IDLE: begin
        if (q_valid && out_free) begin
          pop = 1'b1;
          case (head.op)
            OP_PUT, OP_LF: begin
              if (head.op == OP_PUT) begin
                we    = 1'b1;
                waddr = cur_addr;
                wdata = {attr, head.ch};
              end
              if (head.op == OP_PUT && col_r != LAST_COL) begin
                col_nxt = col_r + 1'b1;
                ld      = 1'b1;
              end else begin
                col_nxt = '0;
                if (row_r == LAST_ROW) begin
                  scan_nxt  = '0;
                  state_nxt = BK_SCROLL;
                end else begin
                  row_nxt = row_r + 1'b1;
                  ld      = 1'b1;
                end
              end
            end
            OP_CR: begin
              col_nxt = '0;
              ld      = 1'b1;
            end
            OP_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              scan_nxt  = '0;
              state_nxt = BK_CLEAR;
            end
            OP_READ: begin
              raddr     = head.addr;
              state_nxt = BK_READ;
            end
            default: ld = 1'b1;
          endcase
        end
      end
      BK_READ: begin
        ld        = 1'b1;
        ld_cell   = rdata_r;
        state_nxt = BK_IDLE;
      end
      BK_SCROLL: begin
        if (scan_r != '0) begin
          we    = 1'b1;
          waddr = scan_r - 1'b1;
          wdata = rdata_r;
        end
        if (scan_r == SCROLL_END) begin
          state_nxt = BK_BLANK;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      BK_BLANK: begin
        we = 1'b1;
        if (scan_r == LAST_CELL) begin
          scan_nxt  = '0;
          state_nxt = BK_IDLE;
          ld        = 1'b1;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
    res_valid_nxt = ld ? 1'b1 : (res_ready ? 1'b0 : res_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_INIT;
      scan_r      <= '0;
      col_r       <= '0;
      row_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      res_r.cdata <= ld_cell;
      res_r.col   <= COL_OUT_W'(col_nxt);
      res_r.row   <= ROW_OUT_W'(row_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      cells_r[waddr] <= wdata;
    end
    rdata_r <= cells_r[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/tmcw_checker.sv]
// Port-level checks for the text mode console writer, bound to the top level.
// Depends on tmcw_pkg.
`default_nettype none

module tmcw_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);
  import tmcw_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_tdata[22:16]) < COLUMNS) && (32'(out_tdata[27:23]) < ROWS))
    else $error("cursor outside screen");

  a_init_pass: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_tready && !out_tvalid)
    else $error("input taken during clearing pass");

endmodule

bind text_mode_console_writer_core tmcw_checker u_chk (.*);

`default_nettype wire
